### design/bqfe_pkg.sv
// ----------------------------------------------------------------------------
// bqfe_pkg
// Shared types, constants and fixed-point helpers of the bicubic quad field
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bqfe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NODE_COUNT = 16;
  localparam int NODE_IDX_W = 4;
  localparam int VAL_W = 32;
  localparam int COORD_W = FRAC_BITS + 1;
  // 3 * coordinate, coordinate clamped to 1.0.
  localparam int S_W = FRAC_BITS + 2;
  // Multiplier operand A (row sums, nodal values) and B (bases, factors).
  localparam int AW = 38;
  localparam int BW = 21;
  localparam int PW = AW + BW;
  localparam int ACC_W = 64;
  // Width of the derivative quadratics before rounding.
  localparam int DW = 44;

  localparam int NUM_STEPS = 60;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
  localparam logic [STEP_W-1:0] ROW_FIRST = STEP_W'(16);
  localparam logic [STEP_W-1:0] CMB_FIRST = STEP_W'(48);

  // Operation groups of the sequencer.
  localparam logic [1:0] GRP_BASIS = 2'd0;
  localparam logic [1:0] GRP_ROW = 2'd1;
  localparam logic [1:0] GRP_COMB = 2'd2;

  // Basis micro-operations, one per step within a coordinate.
  localparam logic [2:0] K_P01 = 3'd0;
  localparam logic [2:0] K_P02 = 3'd1;
  localparam logic [2:0] K_P12 = 3'd2;
  localparam logic [2:0] K_SQ = 3'd3;
  localparam logic [2:0] K_V3 = 3'd4;
  localparam logic [2:0] K_V2 = 3'd5;
  localparam logic [2:0] K_V1 = 3'd6;
  localparam logic [2:0] K_V0 = 3'd7;

  // Final combination sums.
  localparam logic [1:0] CMB_FV = 2'd0;
  localparam logic [1:0] CMB_DU = 2'd1;
  localparam logic [1:0] CMB_DV = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [1:0] grp;
    logic       coord_v;
    logic [2:0] k;
    logic [1:0] b;
    logic [1:0] a;
    logic [1:0] sub;
    logic       last;
  } op_t;

  // Node number stored at grid position (row * 4 + column).
  function automatic logic [NODE_IDX_W-1:0] node_at(input logic [3:0] pos);
    logic [NODE_IDX_W-1:0] n;
    case (pos)
      4'd0:  n = 4'd0;
      4'd1:  n = 4'd4;
      4'd2:  n = 4'd5;
      4'd3:  n = 4'd1;
      4'd4:  n = 4'd11;
      4'd5:  n = 4'd12;
      4'd6:  n = 4'd13;
      4'd7:  n = 4'd6;
      4'd8:  n = 4'd10;
      4'd9:  n = 4'd15;
      4'd10: n = 4'd14;
      4'd11: n = 4'd7;
      4'd12: n = 4'd3;
      4'd13: n = 4'd9;
      4'd14: n = 4'd8;
      default: n = 4'd2;
    endcase
    return n;
  endfunction

  // Round to nearest, ties toward +infinity, dividing by 2**sh.
  function automatic logic signed [ACC_W-1:0] rnd_shift(
      input logic signed [ACC_W-1:0] x, input int sh);
    logic signed [ACC_W-1:0] half;
    half = 64'sd1 <<< (sh - 1);
    return (x + half) >>> sh;
  endfunction

  // Rounded division by 6 * one, via floor by 2 * one and a reciprocal for 3.
  function automatic logic signed [BW-1:0] div6_round(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    logic [21:0] yp;
    logic [45:0] m;
    logic [21:0] qp;
    y = (x + (64'sd3 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    yp = {y[20], y[20:0]} + 22'd3145728;
    m = yp * 24'd5592406;
    qp = m[45:24] - 22'd1048576;
    return qp[BW-1:0];
  endfunction

  // Clip to signed 32 bits; the top bit reports clipping.
  function automatic logic [VAL_W:0] clip32(input logic signed [ACC_W-1:0] x);
    logic [VAL_W:0] r;
    if (x > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (x < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[VAL_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/bqfe_mul.sv
// ----------------------------------------------------------------------------
// bqfe_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfe_mul (
  input  wire logic                             clk_i,
  input  wire logic signed [bqfe_pkg::AW-1:0]   a_i,
  input  wire logic signed [bqfe_pkg::BW-1:0]   b_i,
  output logic signed      [bqfe_pkg::PW-1:0]   p_o
);

  logic signed [bqfe_pkg::PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### design/bqfe_ctrl.sv
// ----------------------------------------------------------------------------
// bqfe_ctrl
// Step sequencer: walks the sixty multiply steps of one evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          eval_i,
  output logic               busy_o,
  output bqfe_pkg::op_t      op_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;
  logic [bqfe_pkg::STEP_W-1:0] step_q, step_d;
  logic [4:0] idx_row;
  logic [3:0] idx_cmb;
  logic [bqfe_pkg::STEP_W-1:0] row_off, cmb_off;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (eval_i) begin
          state_d = ST_RUN;
          step_d = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        if (step_q == bqfe_pkg::LAST_STEP) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  assign row_off = step_q - bqfe_pkg::ROW_FIRST;
  assign cmb_off = step_q - bqfe_pkg::CMB_FIRST;
  assign idx_row = row_off[4:0];
  assign idx_cmb = cmb_off[3:0];

  always_comb begin
    op_o = '0;
    op_o.vld = (state_q == ST_RUN);
    if (step_q < bqfe_pkg::ROW_FIRST) begin
      op_o.grp = bqfe_pkg::GRP_BASIS;
      op_o.coord_v = step_q[3];
      op_o.k = step_q[2:0];
    end else if (step_q < bqfe_pkg::CMB_FIRST) begin
      op_o.grp = bqfe_pkg::GRP_ROW;
      op_o.b = idx_row[4:3];
      op_o.sub = {1'b0, idx_row[2]};
      op_o.a = idx_row[1:0];
      op_o.last = (idx_row[1:0] == 2'd3);
    end else begin
      op_o.grp = bqfe_pkg::GRP_COMB;
      op_o.sub = idx_cmb[3:2];
      op_o.b = idx_cmb[1:0];
      op_o.last = (idx_cmb[1:0] == 2'd3);
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### design/bicubic_quad_field_evaluator.sv
// ----------------------------------------------------------------------------
// bicubic_quad_field_evaluator
// Sixteen-node bicubic Lagrange quad element: stores nodal values and returns
// the interpolated value and both derivatives at a point.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   command   start / busy       cmd_i, node_index_i, node_value_i,
//                                u_coord_i, v_coord_i
//   result    done_o (strobe)    field_value_o, deriv_u_o, deriv_v_o,
//                                saturated_o
//
// A load word is written to node storage at the accepting edge and busy stays low.
// An evaluate word runs 60 steps through the single shared multiplier: eight
// basis products per coordinate, 32 row products and 12 combining products.
// The result strobe rises after the last combining product is written back,
// once busy has fallen again. Busy covers the run of steps and a flush state.
// Reset clears every node to zero; the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bicubic_quad_field_evaluator (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cmd_i,
  input  wire logic [3:0]          node_index_i,
  input  wire logic signed [31:0]  node_value_i,
  input  wire logic [16:0]         u_coord_i,
  input  wire logic [16:0]         v_coord_i,
  output logic                     done_o,
  output logic signed [31:0]       field_value_o,
  output logic signed [31:0]       deriv_u_o,
  output logic signed [31:0]       deriv_v_o,
  output logic                     saturated_o
);

  localparam int F = bqfe_pkg::FRAC_BITS;
  localparam int BW = bqfe_pkg::BW;
  localparam int AW = bqfe_pkg::AW;
  localparam int PW = bqfe_pkg::PW;
  localparam int DW = bqfe_pkg::DW;
  localparam int SW = bqfe_pkg::S_W;
  localparam int ACC_W = bqfe_pkg::ACC_W;
  localparam logic signed [BW-1:0] ONE_B = BW'(1 << F);

  logic accept, load_en, eval_en;
  bqfe_pkg::op_t op, wb_q;

  // Node storage, cleared by reset.
  logic signed [31:0] node_q [bqfe_pkg::NODE_COUNT];

  // Scaled coordinates s = 3 * clamp(t).
  logic [SW-1:0] su_q, sv_q;

  // Basis scratch and results.
  logic signed [BW-1:0] p01_q, p02_q, p12_q;
  logic signed [BW-1:0] bu_q [4];
  logic signed [BW-1:0] dbu_q [4];
  logic signed [BW-1:0] bv_q [4];
  logic signed [BW-1:0] dbv_q [4];

  // Row sums along u and their u-derivatives.
  logic signed [AW-1:0] r_q [4];
  logic signed [AW-1:0] dr_q [4];

  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0] fv_q, du_q, dv_q;
  logic sat_q, done_q;

  assign accept = start && !busy;
  assign load_en = accept && !cmd_i;
  assign eval_en = accept && cmd_i;

  bqfe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .eval_i (eval_en),
    .busy_o (busy),
    .op_o   (op)
  );

  // Clamp a coordinate to 1.0 and scale it by three.
  function automatic logic [SW-1:0] scale3(input logic [16:0] t);
    logic [SW-1:0] x;
    x = (t > 17'(1 << F)) ? SW'(1 << F) : SW'(t);
    return x + (x << 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Operand selection for the step being issued.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] s_iss;
  logic signed [BW-1:0] s_b, d1, d2, d3;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  assign s_iss = op.coord_v ? sv_q : su_q;
  assign s_b = BW'(s_iss);
  assign d1 = s_b - ONE_B;
  assign d2 = s_b - (ONE_B <<< 1);
  assign d3 = s_b - ONE_B - (ONE_B <<< 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op.grp)
      bqfe_pkg::GRP_BASIS: begin
        unique case (op.k)
          bqfe_pkg::K_P01: begin mul_a = AW'(s_b); mul_b = d1; end
          bqfe_pkg::K_P02: begin mul_a = AW'(s_b); mul_b = d2; end
          bqfe_pkg::K_P12: begin mul_a = AW'(d1); mul_b = d2; end
          bqfe_pkg::K_SQ:  begin mul_a = AW'(s_b); mul_b = s_b; end
          bqfe_pkg::K_V3:  begin mul_a = AW'(p01_q); mul_b = d2; end
          bqfe_pkg::K_V2:  begin mul_a = -AW'(p01_q); mul_b = d3; end
          bqfe_pkg::K_V1:  begin mul_a = AW'(p02_q); mul_b = d3; end
          default:         begin mul_a = -AW'(p12_q); mul_b = d3; end
        endcase
      end
      bqfe_pkg::GRP_ROW: begin
        mul_a = AW'(node_q[bqfe_pkg::node_at({op.b, op.a})]);
        mul_b = op.sub[0] ? dbu_q[op.a] : bu_q[op.a];
      end
      bqfe_pkg::GRP_COMB: begin
        case (op.sub)
          bqfe_pkg::CMB_FV: begin mul_a = r_q[op.b]; mul_b = bv_q[op.b]; end
          bqfe_pkg::CMB_DU: begin mul_a = dr_q[op.b]; mul_b = bv_q[op.b]; end
          default:          begin mul_a = r_q[op.b]; mul_b = dbv_q[op.b]; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bqfe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------------------
  // Write-back of the product issued in the previous cycle.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] prod64, rnd1_64, rnd2_64, sum64, res64;
  logic signed [BW-1:0] rnd1, rnd2, quot6;
  logic [SW-1:0] s_wb;
  logic signed [DW-1:0] q_d, t3, so, oo, e0, e1, e2, e3;
  logic signed [ACC_W-1:0] g0, g1, g2, g3;
  logic signed [BW-1:0] der0, der1, der2, der3;
  logic [32:0] clip;

  assign prod64 = ACC_W'(prod);
  assign rnd1_64 = bqfe_pkg::rnd_shift(prod64, F);
  assign rnd2_64 = bqfe_pkg::rnd_shift(prod64, F + 1);
  assign rnd1 = rnd1_64[BW-1:0];
  assign rnd2 = rnd2_64[BW-1:0];
  assign quot6 = bqfe_pkg::div6_round(prod64);

  // Derivative quadratics, formed exactly at twice the fraction bits.
  assign s_wb = wb_q.coord_v ? sv_q : su_q;
  assign q_d = DW'(prod);
  assign t3 = q_d + (q_d <<< 1);
  assign so = DW'(s_wb) <<< F;
  assign oo = DW'(1) <<< (2 * F);
  assign e0 = -(t3 - 44'sd12 * so + 44'sd11 * oo);
  assign e1 = 44'sd3 * (t3 - 44'sd10 * so + 44'sd6 * oo);
  assign e2 = -44'sd3 * (t3 - 44'sd8 * so + 44'sd3 * oo);
  assign e3 = t3 - 44'sd6 * so + 44'sd2 * oo;
  assign g0 = bqfe_pkg::rnd_shift(ACC_W'(e0), 2 * F + 1);
  assign g1 = bqfe_pkg::rnd_shift(ACC_W'(e1), 2 * F + 1);
  assign g2 = bqfe_pkg::rnd_shift(ACC_W'(e2), 2 * F + 1);
  assign g3 = bqfe_pkg::rnd_shift(ACC_W'(e3), 2 * F + 1);
  assign der0 = g0[BW-1:0];
  assign der1 = g1[BW-1:0];
  assign der2 = g2[BW-1:0];
  assign der3 = g3[BW-1:0];

  // Multiply-accumulate: the last product of a group rounds the sum back.
  assign sum64 = acc_q + prod64;
  assign res64 = bqfe_pkg::rnd_shift(sum64, F);
  assign clip = bqfe_pkg::clip32(res64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= '0;
      acc_q <= '0;
      sat_q <= 1'b0;
      done_q <= 1'b0;
      for (int i = 0; i < bqfe_pkg::NODE_COUNT; i++) begin
        node_q[i] <= '0;
      end
    end else begin
      wb_q <= op;
      done_q <= wb_q.vld && (wb_q.grp == bqfe_pkg::GRP_COMB) && wb_q.last &&
                (wb_q.sub == bqfe_pkg::CMB_DV);
      if (load_en) begin
        node_q[node_index_i] <= node_value_i;
      end
      if (eval_en) begin
        sat_q <= 1'b0;
      end else if (wb_q.vld && (wb_q.grp == bqfe_pkg::GRP_COMB) && wb_q.last) begin
        sat_q <= sat_q | clip[32];
      end
      if (wb_q.vld && (wb_q.grp != bqfe_pkg::GRP_BASIS)) begin
        acc_q <= wb_q.last ? '0 : sum64;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      su_q <= scale3(u_coord_i);
      sv_q <= scale3(v_coord_i);
    end
    if (wb_q.vld) begin
      unique case (wb_q.grp)
        bqfe_pkg::GRP_BASIS: begin
          case (wb_q.k)
            bqfe_pkg::K_P01: p01_q <= rnd1;
            bqfe_pkg::K_P02: p02_q <= rnd1;
            bqfe_pkg::K_P12: p12_q <= rnd1;
            bqfe_pkg::K_SQ: begin
              if (wb_q.coord_v) begin
                dbv_q[0] <= der0; dbv_q[1] <= der1;
                dbv_q[2] <= der2; dbv_q[3] <= der3;
              end else begin
                dbu_q[0] <= der0; dbu_q[1] <= der1;
                dbu_q[2] <= der2; dbu_q[3] <= der3;
              end
            end
            bqfe_pkg::K_V3: begin
              if (wb_q.coord_v) bv_q[3] <= quot6; else bu_q[3] <= quot6;
            end
            bqfe_pkg::K_V2: begin
              if (wb_q.coord_v) bv_q[2] <= rnd2; else bu_q[2] <= rnd2;
            end
            bqfe_pkg::K_V1: begin
              if (wb_q.coord_v) bv_q[1] <= rnd2; else bu_q[1] <= rnd2;
            end
            default: begin
              if (wb_q.coord_v) bv_q[0] <= quot6; else bu_q[0] <= quot6;
            end
          endcase
        end
        bqfe_pkg::GRP_ROW: begin
          if (wb_q.last) begin
            if (wb_q.sub[0]) dr_q[wb_q.b] <= res64[AW-1:0];
            else r_q[wb_q.b] <= res64[AW-1:0];
          end
        end
        bqfe_pkg::GRP_COMB: begin
          if (wb_q.last) begin
            case (wb_q.sub)
              bqfe_pkg::CMB_FV: fv_q <= clip[31:0];
              bqfe_pkg::CMB_DU: du_q <= clip[31:0];
              default:          dv_q <= clip[31:0];
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign field_value_o = fv_q;
  assign deriv_u_o = du_q;
  assign deriv_v_o = dv_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

### design/bqfe_checker.sv
// ----------------------------------------------------------------------------
// bqfe_checker
// Port-level checks of the command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfe_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic cmd_i,
  input wire logic done_o
);

  // An evaluate word keeps the block busy.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i) |=> busy)
    else $error("evaluate word did not raise busy");

  // A load word never produces busy.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cmd_i) |=> !busy)
    else $error("load word raised busy");

  // The result strobe arrives once the block is idle again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // One result word per evaluation: no strobe twice in a row.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

endmodule

bind bicubic_quad_field_evaluator bqfe_checker u_bqfe_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o)
);

`default_nettype wire
